### rtl/core/nls_pkg.sv
// Shared constants, status codes and result type of the numeric literal scanner.
`timescale 1ns / 1ps

package nls_pkg;

  // Longest literal that is accepted, in characters
  localparam int MAX_LEN = 255;

  // Width of the internal counters: holds MAX_LEN, never under the 8 reported bits
  localparam int CNT_W = ($clog2(MAX_LEN + 1) > 8) ? $clog2(MAX_LEN + 1) : 8;
  localparam logic [CNT_W-1:0] MAX_LEN_C = CNT_W'(MAX_LEN);

  // Result status codes
  typedef enum logic [3:0] {
    ST_OK            = 4'd0,
    ST_EMPTY         = 4'd1,
    ST_UNDERSCORE    = 4'd2,
    ST_P_NOT_HEX     = 4'd3,
    ST_BAD_CHAR      = 4'd4,
    ST_BAD_DIGIT     = 4'd5,
    ST_FLOAT_BASE    = 4'd6,
    ST_E_IN_HEX      = 4'd7,
    ST_NO_EXP_DIGITS = 4'd8,
    ST_EXP_BASE      = 4'd9,
    ST_BAD_EXP_CHAR  = 4'd10,
    ST_NO_DIGITS     = 4'd11,
    ST_TOO_LONG      = 4'd12
  } nls_status_t;

  // Exponent sign codes
  localparam logic [1:0] SIGN_NONE  = 2'd0;
  localparam logic [1:0] SIGN_PLUS  = 2'd1;
  localparam logic [1:0] SIGN_MINUS = 2'd2;

  // Radix values
  localparam logic [4:0] RADIX_2  = 5'd2;
  localparam logic [4:0] RADIX_8  = 5'd8;
  localparam logic [4:0] RADIX_10 = 5'd10;
  localparam logic [4:0] RADIX_16 = 5'd16;

  // Prefix lengths
  localparam logic [1:0] PREFIX_NONE = 2'd0;
  localparam logic [1:0] PREFIX_ZERO = 2'd1;
  localparam logic [1:0] PREFIX_FULL = 2'd2;

  // One result item, as it leaves the scan engine
  typedef struct packed {
    nls_status_t status;
    logic [4:0]  radix;
    logic        has_point;
    logic [1:0]  prefix_length;
    logic [7:0]  integer_length;
    logic [7:0]  fraction_length;
    logic        exponent_marker;
    logic [1:0]  exp_sign_code;
    logic [7:0]  exponent_length;
    logic [7:0]  consumed_count;
  } nls_result_t;

endpackage

### rtl/core/nls_engine.sv
// Scan state register and single-pass character step of the literal scanner.
`timescale 1ns / 1ps

module nls_engine import nls_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_valid,
  input  logic [7:0]  char_code,
  input  logic        end_of_text,
  input  logic        out_free,
  output logic        consume,
  output logic        produce,
  output nls_result_t result
);

  typedef enum logic [2:0] {
    PH_START,
    PH_ZERO,
    PH_INT,
    PH_FRAC,
    PH_EXP_FIRST,
    PH_EXP_SIGN,
    PH_EXP
  } phase_t;

  typedef struct packed {
    phase_t           phase;
    logic [4:0]       radix;
    logic             octal;
    logic             group_start;
    logic             last_us;
    logic             point;
    logic [1:0]       prefix;
    logic [CNT_W-1:0] int_cnt;
    logic [CNT_W-1:0] frac_cnt;
    logic             exp_marker;
    logic [1:0]       exp_sign;
    logic [CNT_W-1:0] exp_cnt;
    logic [CNT_W-1:0] total;
  } scan_state_t;

  localparam scan_state_t STATE_RESET = '{
    phase:       PH_START,
    radix:       RADIX_10,
    octal:       1'b0,
    group_start: 1'b1,
    last_us:     1'b0,
    point:       1'b0,
    prefix:      PREFIX_NONE,
    int_cnt:     '0,
    frac_cnt:    '0,
    exp_marker:  1'b0,
    exp_sign:    SIGN_NONE,
    exp_cnt:     '0,
    total:       '0
  };

  scan_state_t state_r, state_nxt, s;
  logic        fin;
  nls_status_t stat;

  // Character classes
  logic       is_dig, is_letter, is_us, is_point;
  logic [7:0] lc;
  logic       room;

  assign is_dig    = (char_code >= "0") && (char_code <= "9");
  assign is_letter = ((char_code >= "a") && (char_code <= "z")) ||
                     ((char_code >= "A") && (char_code <= "Z"));
  assign is_us     = (char_code == "_");
  assign is_point  = (char_code == ".");
  assign lc        = char_code | 8'h20;
  assign room      = (state_r.total < MAX_LEN_C);

  // Step one item through the scan rules
  always_comb begin
    logic       run_dig, d_end, run_exp, e_end, handled, stop, v_ok, is_frac;
    logic [4:0] v;
    s       = state_r;
    fin     = 1'b0;
    stat    = ST_OK;
    run_dig = 1'b0;
    d_end   = end_of_text;
    run_exp = 1'b0;
    e_end   = end_of_text;
    handled = 1'b0;
    stop    = 1'b0;
    v_ok    = 1'b0;
    v       = '0;
    is_frac = 1'b0;

    // Dispatch on phase
    case (state_r.phase)
      PH_START: begin
        if (end_of_text) begin
          fin  = 1'b1;
          stat = ST_EMPTY;
        end else if (char_code == "0") begin
          if (!room) begin
            fin  = 1'b1;
            stat = ST_TOO_LONG;
          end else begin
            s.total = s.total + 1'b1;
            s.phase = PH_ZERO;
          end
        end else begin
          s.phase = PH_INT;
          run_dig = 1'b1;
          d_end   = 1'b0;
        end
      end
      PH_ZERO: begin
        s.phase       = PH_INT;
        s.group_start = 1'b0;
        if (!end_of_text && is_letter && (lc == "x" || lc == "b" || lc == "o")) begin
          if (!room) begin
            fin  = 1'b1;
            stat = ST_TOO_LONG;
          end else begin
            s.total  = s.total + 1'b1;
            s.radix  = (lc == "x") ? RADIX_16 : (lc == "b") ? RADIX_2 : RADIX_8;
            s.prefix = PREFIX_FULL;
          end
        end else if (!end_of_text && (is_us || is_dig)) begin
          s.radix  = RADIX_8;
          s.octal  = 1'b1;
          s.prefix = PREFIX_ZERO;
          run_dig  = 1'b1;
          d_end    = 1'b0;
        end else begin
          s.radix   = RADIX_10;
          s.int_cnt = CNT_W'(1);
          run_dig   = 1'b1;
        end
      end
      PH_INT, PH_FRAC: begin
        run_dig = 1'b1;
      end
      PH_EXP_FIRST: begin
        if (end_of_text) begin
          fin  = 1'b1;
          stat = ST_NO_EXP_DIGITS;
        end else begin
          if (s.octal) begin
            s.prefix  = PREFIX_NONE;
            s.int_cnt = s.int_cnt + 1'b1;
            s.octal   = 1'b0;
            s.radix   = RADIX_10;
          end
          if (s.radix != RADIX_10 && s.radix != RADIX_16) begin
            fin  = 1'b1;
            stat = ST_EXP_BASE;
          end else if (char_code == "+" || char_code == "-") begin
            if (!room) begin
              fin  = 1'b1;
              stat = ST_TOO_LONG;
            end else begin
              s.total    = s.total + 1'b1;
              s.exp_sign = (char_code == "+") ? SIGN_PLUS : SIGN_MINUS;
              s.phase    = PH_EXP_SIGN;
            end
          end else begin
            s.phase = PH_EXP;
            run_exp = 1'b1;
            e_end   = 1'b0;
          end
        end
      end
      PH_EXP_SIGN: begin
        if (end_of_text) begin
          fin  = 1'b1;
          stat = ST_NO_EXP_DIGITS;
        end else begin
          s.phase = PH_EXP;
          run_exp = 1'b1;
          e_end   = 1'b0;
        end
      end
      default: begin
        s.phase = PH_EXP;
        run_exp = 1'b1;
      end
    endcase

    // Integer and fraction digits
    if (run_dig) begin
      is_frac = (s.phase == PH_FRAC);
      if (!d_end) begin
        if (is_us) begin
          handled = 1'b1;
          if (s.group_start || s.last_us) begin
            fin  = 1'b1;
            stat = ST_UNDERSCORE;
          end else if (!room) begin
            fin  = 1'b1;
            stat = ST_TOO_LONG;
          end else begin
            s.total = s.total + 1'b1;
            if (is_frac) s.frac_cnt = s.frac_cnt + 1'b1;
            else s.int_cnt = s.int_cnt + 1'b1;
            s.last_us = 1'b1;
          end
        end else begin
          if (is_dig) begin
            v_ok = 1'b1;
            v    = 5'(char_code - "0");
          end else if (is_letter) begin
            if (lc == "e" && (s.radix == RADIX_10 || s.octal)) begin
              stop = 1'b1;
            end else if (lc == "p") begin
              if (s.radix != RADIX_16) begin
                handled = 1'b1;
                fin     = 1'b1;
                stat    = ST_P_NOT_HEX;
              end else begin
                stop = 1'b1;
              end
            end else if (lc >= "a" && lc <= "f") begin
              v_ok = 1'b1;
              v    = 5'(lc - "a") + 5'd10;
            end else begin
              handled = 1'b1;
              fin     = 1'b1;
              stat    = ST_BAD_CHAR;
            end
          end
          if (!handled && !stop && v_ok) begin
            handled = 1'b1;
            if (v >= s.radix) begin
              fin  = 1'b1;
              stat = ST_BAD_DIGIT;
            end else if (!room) begin
              fin  = 1'b1;
              stat = ST_TOO_LONG;
            end else begin
              s.total = s.total + 1'b1;
              if (is_frac) s.frac_cnt = s.frac_cnt + 1'b1;
              else s.int_cnt = s.int_cnt + 1'b1;
              s.last_us     = 1'b0;
              s.group_start = 1'b0;
            end
          end
        end
      end
      // Part ends here: point, exponent prefix or end of the literal
      if (!handled) begin
        if (s.last_us) begin
          fin  = 1'b1;
          stat = ST_UNDERSCORE;
        end else begin
          s.group_start = 1'b1;
          s.last_us     = 1'b0;
          if (!d_end && is_point && s.phase == PH_INT) begin
            s.point = 1'b1;
            if (s.octal) begin
              s.prefix  = PREFIX_NONE;
              s.int_cnt = s.int_cnt + 1'b1;
              s.octal   = 1'b0;
              s.radix   = RADIX_10;
            end
            if (s.radix != RADIX_10 && s.radix != RADIX_16) begin
              fin  = 1'b1;
              stat = ST_FLOAT_BASE;
            end else if (!room) begin
              fin  = 1'b1;
              stat = ST_TOO_LONG;
            end else begin
              s.total = s.total + 1'b1;
              s.phase = PH_FRAC;
            end
          end else if (!d_end && (lc == "e" || lc == "p") && is_letter) begin
            if (lc == "e" && s.radix == RADIX_16) begin
              fin  = 1'b1;
              stat = ST_E_IN_HEX;
            end else if (lc == "p" && s.radix != RADIX_16) begin
              fin  = 1'b1;
              stat = ST_P_NOT_HEX;
            end else if (!room) begin
              fin  = 1'b1;
              stat = ST_TOO_LONG;
            end else begin
              s.total      = s.total + 1'b1;
              s.exp_marker = 1'b1;
              s.phase      = PH_EXP_FIRST;
            end
          end else begin
            fin  = 1'b1;
            stat = (s.int_cnt == '0 && s.frac_cnt == '0) ? ST_NO_DIGITS : ST_OK;
          end
        end
      end
    end

    // Exponent digits
    if (run_exp) begin
      if (!e_end && is_us) begin
        if (s.group_start || s.last_us) begin
          fin  = 1'b1;
          stat = ST_UNDERSCORE;
        end else if (!room) begin
          fin  = 1'b1;
          stat = ST_TOO_LONG;
        end else begin
          s.total   = s.total + 1'b1;
          s.exp_cnt = s.exp_cnt + 1'b1;
          s.last_us = 1'b1;
        end
      end else if (!e_end && is_dig) begin
        if (!room) begin
          fin  = 1'b1;
          stat = ST_TOO_LONG;
        end else begin
          s.total       = s.total + 1'b1;
          s.exp_cnt     = s.exp_cnt + 1'b1;
          s.last_us     = 1'b0;
          s.group_start = 1'b0;
        end
      end else if (!e_end && (is_point || is_letter)) begin
        fin  = 1'b1;
        stat = ST_BAD_EXP_CHAR;
      end else begin
        fin = 1'b1;
        if (s.last_us) stat = ST_UNDERSCORE;
        else if (s.int_cnt == '0 && s.frac_cnt == '0) stat = ST_NO_DIGITS;
        else stat = ST_OK;
      end
    end
  end

  // Advance on every item; a finished literal waits only for a free result slot
  assign produce   = item_valid && fin;
  assign consume   = item_valid && (!fin || out_free);
  assign state_nxt = fin ? STATE_RESET : s;

  // Report the scan state as it stood when the literal ended
  always_comb begin
    result.status          = stat;
    result.radix           = s.radix;
    result.has_point       = s.point;
    result.prefix_length   = s.prefix;
    result.integer_length  = s.int_cnt[7:0];
    result.fraction_length = s.frac_cnt[7:0];
    result.exponent_marker = s.exp_marker;
    result.exp_sign_code   = s.exp_sign;
    result.exponent_length = s.exp_cnt[7:0];
    result.consumed_count  = s.total[7:0];
  end

  // Hold scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (consume) begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/core/nls_out_reg.sv
// Result register of the literal scanner, holding one item until it is taken.
`timescale 1ns / 1ps

module nls_out_reg import nls_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  nls_result_t load_data,
  input  logic        out_tready,
  output logic        out_tvalid,
  output logic        out_free,
  output nls_result_t out_data
);

  logic        valid_r, valid_nxt;
  nls_result_t data_r;

  assign out_free   = !valid_r || out_tready;
  assign valid_nxt  = load ? 1'b1 : (out_tready ? 1'b0 : valid_r);
  assign out_tvalid = valid_r;
  assign out_data   = data_r;

  // Hold valid until taken; payload loads without reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule

### rtl/core/number_literal_scanner_core.sv
// Top level of the numeric literal scanner: input register, scan engine, result register.
`timescale 1ns / 1ps

// Takes one character per item (tuser[0] high marks end of text) and scans one
// numeric literal: 0x/0b/0o prefixes, octal after a leading zero, underscores,
// fraction and e/p exponent. The character that ends a literal is dropped, and
// one result item reports status, radix and part lengths; then the scanner
// re-arms. One item is taken every clock cycle while the input side does not stall;
// each item passes the input register and the single-pass character step, and the
// result is loaded into the result register when the item that ends the literal
// leaves the input register. The input side stalls only when a result is due
// while the result register is still occupied.

module number_literal_scanner_core import nls_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic [0:0]  in_tuser,   // [0] end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  // [3:0] status, [8:4] radix, [9] has_point, [11:10] prefix_length,
  // [19:12] integer_length, [27:20] fraction_length, [28] exponent_marker,
  // [30:29] exp_sign_code, [38:31] exponent_length, [46:39] consumed_count, [47] zero
  output logic [47:0] out_tdata
);

  logic        in_valid_r, in_valid_nxt;
  logic [7:0]  char_r;
  logic        eot_r;
  logic        consume, produce, out_free;
  nls_result_t result, out_data;

  // Input register: refill whenever the held item moves on
  assign in_tready    = !in_valid_r || consume;
  assign in_valid_nxt = in_tvalid ? 1'b1 : (consume ? 1'b0 : in_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      char_r <= in_tdata;
      eot_r  <= in_tuser[0];
    end
  end

  nls_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (in_valid_r),
    .char_code   (char_r),
    .end_of_text (eot_r),
    .out_free    (out_free),
    .consume     (consume),
    .produce     (produce),
    .result      (result)
  );

  nls_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (produce && consume),
    .load_data  (result),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_free   (out_free),
    .out_data   (out_data)
  );

  // Pack result fields, highest first
  assign out_tdata = {1'b0,
                      out_data.consumed_count,
                      out_data.exponent_length,
                      out_data.exp_sign_code,
                      out_data.exponent_marker,
                      out_data.fraction_length,
                      out_data.integer_length,
                      out_data.prefix_length,
                      out_data.has_point,
                      out_data.radix,
                      out_data.status};

  // A result is only loaded when the result slot can take it
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    produce && consume |-> out_free)
    else $error("result loaded while result register busy");

  // The input item is never dropped while a due result is stalled
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && produce && !out_free |=> in_valid_r && $stable(char_r) && $stable(eot_r))
    else $error("input item lost during result stall");

  // Radix is always a supported base
  a_radix: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_data.radix == RADIX_2 || out_data.radix == RADIX_8 ||
                    out_data.radix == RADIX_10 || out_data.radix == RADIX_16))
    else $error("result radix out of range");

  // An empty literal consumed nothing
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_data.status == ST_EMPTY |-> out_data.consumed_count == 8'd0 &&
    out_data.radix == RADIX_10)
    else $error("empty result with nonzero count");

endmodule
